// ===== src/multilevel_feedback_scheduler_unit_assert.svh =====
// assertion macros for the scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MFS_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("scheduler assertion failed");
`define MFS_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("scheduler assertion failed");
`else
`define MFS_ASSERT_IMP(lbl, clk, rst, a, b)
`define MFS_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== src/mfs_pkg.sv =====
package mfs_pkg;
   localparam int THREADS = 64;
   localparam int LEVELS  = 62;
   localparam int TID_W   = 6;
   localparam int LVL_W   = 6;
   localparam int SLICE_W = 9;
   localparam int TIMER_W = 17;
   localparam int BASE_W  = 8;
   localparam int THR_W   = 16;
   localparam int CSR_W   = 16;

   localparam logic CSR_SLICE_BASE = 1'b0;
   localparam logic CSR_BOOST_THR  = 1'b1;
   localparam logic MODE_ENQ       = 1'b0;
   localparam logic MODE_SCHED     = 1'b1;

   localparam logic [LVL_W-1:0] LVL_CRIT = LVL_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0] LVL_LAST_BOOST = LVL_W'(LEVELS - 2);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENQ, ST_ENQ2, ST_SCH0, ST_SCH1, ST_SCH2, ST_CHG,
      ST_B1, ST_BR, ST_BL, ST_BW, ST_D0, ST_D1, ST_D2, ST_DONE
   } state_type;

   typedef struct packed {
      logic             found;
      logic [LVL_W-1:0] idx;
   } enc_type;

   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic [TID_W-1:0] link;
   } thr_ent_type;

   typedef struct packed {
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
   } lq_ent_type;

   function automatic logic [SLICE_W-1:0] slice_of(input logic [LVL_W-1:0] lvl,
                                                   input logic [BASE_W-1:0] base);
      slice_of = SLICE_W'({lvl, 1'b0}) + SLICE_W'(base);
   endfunction
endpackage

// ===== src/mfs_prio_enc.sv =====
module mfs_prio_enc import mfs_pkg::*; (
   input  logic [LEVELS-1:0] bits,
   output enc_type           res
);
   // lowest set bit wins
   always_comb begin
      res = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            res.found = 1'b1;
            res.idx   = LVL_W'(i);
         end
      end
   end
endmodule

// ===== src/multilevel_feedback_scheduler_unit.sv =====
// multilevel feedback queue scheduler, dispatch core
// req channel: one beat per operation; req_mode low enqueues req_thread_id at
//   req_level (saturated to the critical level), high runs a schedule step for
//   the current thread given by req_thread_id / req_has_current
// rsp channel: exactly one beat per request; enqueue beats carry all zeros,
//   schedule beats carry the dispatched thread, its level and slice, and boosted
// csr port: csr_we writes csr_wdata to register csr_index (0 slice base,
//   1 boost threshold); write only while idle
// one request is in flight at a time; state lives in a thread memory
//   (level, link) and a level-queue memory (head, tail), both with registered reads
// each request runs as a chain of read-then-write steps on the two memories
// the next request is taken only once the block is back in idle after the rsp
//   register loads, so a request never overlaps the one before it
// a boost walks levels 1 .. critical-1 and splices each nonempty level onto
//   the level 0 queue before the dispatch step
// a finished beat waits in the rsp register; the next request is accepted
//   while it waits and the block only holds in its final step while that beat waits under rsp_stall
// synchronous reset clears queue valid bits, boost timer and registers
//   (slice base 10, threshold 1000); memories need no clearing
module multilevel_feedback_scheduler_unit import mfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [TID_W-1:0]   req_thread_id,
   input  logic [LVL_W-1:0]   req_level,
   input  logic               req_has_current,
   input  logic               req_preemptive,
   input  logic               req_current_blocked,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_next_valid,
   output logic [TID_W-1:0]   rsp_next_thread,
   output logic [LVL_W-1:0]   rsp_next_level,
   output logic [SLICE_W-1:0] rsp_next_slice,
   output logic               rsp_boosted,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);
`include "multilevel_feedback_scheduler_unit_assert.svh"

   state_type state_ff, state_in;

   // captured request
   logic             cur_ff, preempt_ff, blocked_ff;
   logic [TID_W-1:0] tid_ff;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   // scheduler state
   logic [LEVELS-1:0]  ne_ff, ne_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [SLICE_W-1:0] charge_ff, charge_in;
   logic [LVL_W-1:0]   idx_ff, idx_in;
   logic [TID_W-1:0]   h0_ff, h0_in, t0_ff, t0_in;
   logic [BASE_W-1:0]  base_ff;
   logic [THR_W-1:0]   thr_ff;

   // result being built
   logic               nv_ff, nv_in, bst_ff, bst_in;
   logic [TID_W-1:0]   nt_ff, nt_in;
   logic [LVL_W-1:0]   nl_ff, nl_in;
   logic [SLICE_W-1:0] ns_ff, ns_in;

   // rsp output register
   logic               rsp_valid_ff, rsp_nv_ff, rsp_bst_ff;
   logic [TID_W-1:0]   rsp_nt_ff;
   logic [LVL_W-1:0]   rsp_nl_ff;
   logic [SLICE_W-1:0] rsp_ns_ff;
   logic               rsp_load;

   // thread memory, masked field writes
   thr_ent_type      thr_mem [THREADS];
   thr_ent_type      thr_rd_ff;
   logic [TID_W-1:0] thr_raddr, thr_waddr;
   logic             thr_we_lvl, thr_we_link;
   logic [LVL_W-1:0] thr_wlvl;
   logic [TID_W-1:0] thr_wlink;

   // level queue memory
   lq_ent_type       lq_mem [LEVELS];
   lq_ent_type       lq_rd_ff;
   logic [LVL_W-1:0] lq_raddr, lq_waddr;
   logic             lq_we_head, lq_we_tail;
   logic [TID_W-1:0] lq_whead, lq_wtail;

   enc_type enc;
   logic    accept;
   logic [LVL_W-1:0]   rd_lvl;
   logic [TIMER_W-1:0] sum;

   mfs_prio_enc u_enc (.bits(ne_ff), .res(enc));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_valid  = rsp_nv_ff;
   assign rsp_next_thread = rsp_nt_ff;
   assign rsp_next_level  = rsp_nl_ff;
   assign rsp_next_slice  = rsp_ns_ff;
   assign rsp_boosted     = rsp_bst_ff;

   always_ff @(posedge clock) begin
      if (thr_we_lvl)  thr_mem[thr_waddr].lvl  <= thr_wlvl;
      if (thr_we_link) thr_mem[thr_waddr].link <= thr_wlink;
      thr_rd_ff <= thr_mem[thr_raddr];
   end

   always_ff @(posedge clock) begin
      if (lq_we_head) lq_mem[lq_waddr].head <= lq_whead;
      if (lq_we_tail) lq_mem[lq_waddr].tail <= lq_wtail;
      lq_rd_ff <= lq_mem[lq_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ne_ff    <= '0;
         timer_ff <= '0;
         base_ff  <= BASE_W'(10);
         thr_ff   <= THR_W'(1000);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ne_ff    <= ne_in;
         timer_ff <= timer_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SLICE_BASE: base_ff <= csr_wdata[BASE_W-1:0];
               CSR_BOOST_THR:  thr_ff  <= csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tid_ff     <= req_thread_id;
         cur_ff     <= req_has_current;
         preempt_ff <= req_preemptive;
         blocked_ff <= req_current_blocked;
         lvl_ff     <= (req_level > LVL_CRIT) ? LVL_CRIT : req_level;
      end else begin
         lvl_ff <= lvl_in;
      end
      charge_ff <= charge_in;
      idx_ff    <= idx_in;
      h0_ff     <= h0_in;
      t0_ff     <= t0_in;
      nv_ff     <= nv_in;
      nt_ff     <= nt_in;
      nl_ff     <= nl_in;
      ns_ff     <= ns_in;
      bst_ff    <= bst_in;
      if (rsp_load) begin
         rsp_nv_ff  <= nv_ff;
         rsp_nt_ff  <= nt_ff;
         rsp_nl_ff  <= nl_ff;
         rsp_ns_ff  <= ns_ff;
         rsp_bst_ff <= bst_ff;
      end
   end

   assign rd_lvl = (thr_rd_ff.lvl > LVL_CRIT) ? LVL_CRIT : thr_rd_ff.lvl;
   assign sum    = timer_ff + TIMER_W'(charge_ff);

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      ne_in     = ne_ff;
      timer_in  = timer_ff;
      charge_in = charge_ff;
      idx_in    = idx_ff;
      h0_in     = h0_ff;
      t0_in     = t0_ff;
      nv_in     = nv_ff;
      nt_in     = nt_ff;
      nl_in     = nl_ff;
      ns_in     = ns_ff;
      bst_in    = bst_ff;
      rsp_load  = 1'b0;
      thr_raddr = tid_ff;
      thr_waddr = tid_ff;
      thr_we_lvl  = 1'b0;
      thr_we_link = 1'b0;
      thr_wlvl  = lvl_ff;
      thr_wlink = tid_ff;
      lq_raddr  = lvl_ff;
      lq_waddr  = lvl_ff;
      lq_we_head = 1'b0;
      lq_we_tail = 1'b0;
      lq_whead  = tid_ff;
      lq_wtail  = tid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               nv_in  = 1'b0;
               nt_in  = '0;
               nl_in  = '0;
               ns_in  = '0;
               bst_in = 1'b0;
               state_in = (req_mode == MODE_ENQ) ? ST_ENQ : ST_SCH0;
            end
         end
         ST_ENQ: begin
            // record level, fetch the queue tail
            thr_we_lvl = 1'b1;
            state_in   = ST_ENQ2;
         end
         ST_ENQ2, ST_SCH2: begin
            // append tid_ff to queue lvl_ff
            if (ne_ff[lvl_ff]) begin
               thr_waddr   = lq_rd_ff.tail;
               thr_we_link = 1'b1;
            end
            lq_we_head = !ne_ff[lvl_ff];
            lq_we_tail = 1'b1;
            ne_in[lvl_ff] = 1'b1;
            state_in = (state_ff == ST_ENQ2) ? ST_DONE : ST_CHG;
         end
         ST_SCH0: begin
            if (cur_ff && !blocked_ff) begin
               state_in = ST_SCH1;
            end else begin
               charge_in = cur_ff ? '0 : SLICE_W'(base_ff);
               state_in  = ST_CHG;
            end
         end
         ST_SCH1: begin
            charge_in = slice_of(rd_lvl, base_ff);
            lvl_in    = (preempt_ff && rd_lvl < LVL_LAST_BOOST) ? rd_lvl + 1'b1 : rd_lvl;
            thr_wlvl  = lvl_in;
            thr_we_lvl = 1'b1;
            lq_raddr  = lvl_in;
            state_in  = ST_SCH2;
         end
         ST_CHG: begin
            if (sum >= TIMER_W'(thr_ff)) begin
               lq_raddr = '0;
               idx_in   = LVL_W'(1);
               state_in = ST_B1;
            end else begin
               timer_in = sum;
               state_in = ST_D0;
            end
         end
         ST_B1: begin
            h0_in = lq_rd_ff.head;
            t0_in = lq_rd_ff.tail;
            state_in = ST_BR;
         end
         ST_BR: begin
            if (idx_ff > LVL_LAST_BOOST) begin
               state_in = ST_BW;
            end else if (ne_ff[idx_ff]) begin
               lq_raddr = idx_ff;
               state_in = ST_BL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_BL: begin
            // splice queue idx_ff onto the level 0 list
            if (ne_ff[0]) begin
               thr_waddr   = t0_ff;
               thr_wlink   = lq_rd_ff.head;
               thr_we_link = 1'b1;
            end else begin
               h0_in = lq_rd_ff.head;
            end
            t0_in = lq_rd_ff.tail;
            ne_in[0] = 1'b1;
            ne_in[idx_ff] = 1'b0;
            idx_in = idx_ff + 1'b1;
            state_in = ST_BR;
         end
         ST_BW: begin
            lq_waddr   = '0;
            lq_whead   = h0_ff;
            lq_wtail   = t0_ff;
            lq_we_head = ne_ff[0];
            lq_we_tail = ne_ff[0];
            timer_in   = '0;
            bst_in     = 1'b1;
            state_in   = ST_D0;
         end
         ST_D0: begin
            if (enc.found) begin
               idx_in   = enc.idx;
               lq_raddr = enc.idx;
               state_in = ST_D1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_D1: begin
            nv_in = 1'b1;
            nt_in = lq_rd_ff.head;
            nl_in = idx_ff;
            ns_in = slice_of(idx_ff, base_ff);
            thr_waddr  = lq_rd_ff.head;
            thr_wlvl   = idx_ff;
            thr_we_lvl = 1'b1;
            thr_raddr  = lq_rd_ff.head;
            if (lq_rd_ff.head == lq_rd_ff.tail) begin
               ne_in[idx_ff] = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_D2;
            end
         end
         ST_D2: begin
            lq_waddr   = idx_ff;
            lq_whead   = thr_rd_ff.link;
            lq_we_head = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a request always leaves idle
   `MFS_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE)
   // boost write-back clears the timer and flags the beat
   `MFS_ASSERT_NXT(a_boost_clears, clock, reset, state_ff == ST_BW, timer_ff == '0 && bst_ff)
   // the level being popped holds a queue
   `MFS_ASSERT_IMP(a_pop_nonempty, clock, reset, state_ff == ST_D1, ne_ff[idx_ff])
endmodule
